// ===== design/complex_min_max_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// complex_min_max_tracker_defines.svh
// Assertion macros for the tracker RTL (used by cmm_stats).
// ----------------------------------------------------------------------------
`ifndef COMPLEX_MIN_MAX_TRACKER_DEFINES_SVH
`define COMPLEX_MIN_MAX_TRACKER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define CMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CMM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CMM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/cmm_pkg.sv =====
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared constants and types for the min/max tracker.
// ----------------------------------------------------------------------------
package cmm_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF  = 32;

    localparam int FIELD_WIDTH = 32;
    localparam int LEVEL_WIDTH = 31;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_WIDTH  = 3;

    // register byte addresses
    localparam logic [ADDR_WIDTH-1:0] REG_BLANK_LEVEL = 3'd0;

    localparam logic [LEVEL_WIDTH-1:0] LEVEL_RESET = 31'h7FFF_FFFF;
    localparam logic signed [FIELD_WIDTH-1:0] LOW_RESET  = 32'sh7FFF_FFFF;
    localparam logic signed [FIELD_WIDTH-1:0] HIGH_RESET = 32'sh8000_0001;

    // per-sample control that travels with the data
    typedef struct packed {
        logic is_complex;
        logic first;
        logic last;
        logic re_blank;
        logic im_blank;
    } flags_t;

    localparam int FLAGS_WIDTH = $bits(flags_t);

endpackage

// ===== design/complex_min_max_tracker.sv =====
// ----------------------------------------------------------------------------
// complex_min_max_tracker: running min/max of real, imag and magnitude
// A sample passes front stages A to D, the root cell row, then the result register.
// Throughput: one sample per cycle; the root cell row resolves one bit per stage.
// The whole pipe freezes while a finished result sits stalled at the output.
// Reset: pipe empty, blank level at max, statistics at their empty values.
// ----------------------------------------------------------------------------
module complex_min_max_tracker #(
    parameter int SAMPLE_WIDTH = cmm_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = cmm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [cmm_pkg::ADDR_WIDTH-1:0]         paddr,
    input  logic [cmm_pkg::DATA_WIDTH-1:0]         pwdata,
    output logic [cmm_pkg::DATA_WIDTH-1:0]         prdata,
    output logic                                   pready,
    // sample channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [cmm_pkg::FIELD_WIDTH-1:0] real_part,
    input  logic signed [cmm_pkg::FIELD_WIDTH-1:0] imag_part,
    input  logic                                   is_complex,
    input  logic                                   first,
    input  logic                                   last,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [cmm_pkg::FIELD_WIDTH-1:0] real_min,
    output logic signed [cmm_pkg::FIELD_WIDTH-1:0] real_max,
    output logic signed [cmm_pkg::FIELD_WIDTH-1:0] imag_min,
    output logic signed [cmm_pkg::FIELD_WIDTH-1:0] imag_max,
    output logic [cmm_pkg::FIELD_WIDTH-1:0]        mag_min,
    output logic [cmm_pkg::FIELD_WIDTH-1:0]        mag_max,
    output logic [cmm_pkg::FIELD_WIDTH-1:0]        blank_count,
    output logic                                   complex_seen
);

    localparam int PW     = 2 * SAMPLE_WIDTH;
    localparam int RW     = SAMPLE_WIDTH + 2;
    localparam int SIDE_W = 2 * SAMPLE_WIDTH + cmm_pkg::FLAGS_WIDTH;

    // ------------------------------------------------------------------
    // Configuration: one register, blank_level, at byte address 0.
    // Writes land on the access phase; pready is tied high.
    // ------------------------------------------------------------------
    logic [cmm_pkg::LEVEL_WIDTH-1:0] blank_level_reg;
    logic                            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == cmm_pkg::REG_BLANK_LEVEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_level_reg <= cmm_pkg::LEVEL_RESET;
        end
        else if (cfg_wr)
        begin
            blank_level_reg <= pwdata[cmm_pkg::LEVEL_WIDTH-1:0];
        end
    end

    assign prdata = (paddr == cmm_pkg::REG_BLANK_LEVEL) ? {1'b0, blank_level_reg} : '0;

    // ------------------------------------------------------------------
    // Flow control: every stage moves together. The pipe only holds
    // when the result register is full and the consumer is stalling,
    // so a transaction is taken every cycle otherwise.
    // ------------------------------------------------------------------
    logic adv;

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // ------------------------------------------------------------------
    // Front end: blank compare, |re|, |im|, squares, sum of squares.
    // ------------------------------------------------------------------
    logic                           d_valid;
    logic [PW-1:0]                  d_sum;
    logic signed [SAMPLE_WIDTH-1:0] d_re;
    logic signed [SAMPLE_WIDTH-1:0] d_im;
    cmm_pkg::flags_t                d_flags;

    cmm_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (in_valid),
        .real_part   (real_part),
        .imag_part   (imag_part),
        .is_complex  (is_complex),
        .first       (first),
        .last        (last),
        .blank_level (blank_level_reg),
        .d_valid     (d_valid),
        .d_sum       (d_sum),
        .d_re        (d_re),
        .d_im        (d_im),
        .d_flags     (d_flags)
    );

    // ------------------------------------------------------------------
    // Square root: a row of SAMPLE_WIDTH cells, MSB first. Each cell
    // pulls two radicand bits, does one trial subtract and passes the
    // partial root, remainder and the sample's sideband to its neighbor.
    // ------------------------------------------------------------------
    logic                    chain_valid [0:SAMPLE_WIDTH];
    logic [PW-1:0]           chain_rad   [0:SAMPLE_WIDTH];
    logic [RW-1:0]           chain_rem   [0:SAMPLE_WIDTH];
    logic [SAMPLE_WIDTH-1:0] chain_root  [0:SAMPLE_WIDTH];
    logic [SIDE_W-1:0]       chain_side  [0:SAMPLE_WIDTH];

    assign chain_valid[0] = d_valid;
    assign chain_rad[0]   = d_sum;
    assign chain_rem[0]   = '0;
    assign chain_root[0]  = '0;
    assign chain_side[0]  = {d_re, d_im, d_flags};

    genvar gi;
    generate
        for (gi = 0; gi < SAMPLE_WIDTH; gi++)
        begin : g_cell
            cmm_sqrt_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .SIDE_WIDTH   (SIDE_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .in_valid  (chain_valid[gi]),
                .in_rad    (chain_rad[gi]),
                .in_rem    (chain_rem[gi]),
                .in_root   (chain_root[gi]),
                .in_side   (chain_side[gi]),
                .out_valid (chain_valid[gi+1]),
                .out_rad   (chain_rad[gi+1]),
                .out_rem   (chain_rem[gi+1]),
                .out_root  (chain_root[gi+1]),
                .out_side  (chain_side[gi+1])
            );
        end
    endgenerate

    // unpack the sideband at the end of the row
    logic signed [SAMPLE_WIDTH-1:0] e_re;
    logic signed [SAMPLE_WIDTH-1:0] e_im;
    cmm_pkg::flags_t                e_flags;

    assign e_re    = chain_side[SAMPLE_WIDTH][SIDE_W-1 -: SAMPLE_WIDTH];
    assign e_im    = chain_side[SAMPLE_WIDTH][SIDE_W-SAMPLE_WIDTH-1 -: SAMPLE_WIDTH];
    assign e_flags = cmm_pkg::flags_t'(chain_side[SAMPLE_WIDTH][cmm_pkg::FLAGS_WIDTH-1:0]);

    // ------------------------------------------------------------------
    // Statistics and result register. The remainder out of the last
    // cell is not needed: the floor root is complete.
    // ------------------------------------------------------------------
    cmm_stats #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_stats (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (chain_valid[SAMPLE_WIDTH]),
        .in_mag       (chain_root[SAMPLE_WIDTH]),
        .in_re        (e_re),
        .in_im        (e_im),
        .in_flags     (e_flags),
        .blank_level  (blank_level_reg),
        .out_valid    (out_valid),
        .real_min     (real_min),
        .real_max     (real_max),
        .imag_min     (imag_min),
        .imag_max     (imag_max),
        .mag_min      (mag_min),
        .mag_max      (mag_max),
        .blank_count  (blank_count),
        .complex_seen (complex_seen)
    );

endmodule

// ===== design/cmm_front.sv =====
// ----------------------------------------------------------------------------
// cmm_front
// Input stage: blank check, absolute values, squares and sum of squares.
// ----------------------------------------------------------------------------
module cmm_front #(
    parameter int SAMPLE_WIDTH = cmm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  logic                                   in_valid,
    input  logic signed [cmm_pkg::FIELD_WIDTH-1:0] real_part,
    input  logic signed [cmm_pkg::FIELD_WIDTH-1:0] imag_part,
    input  logic                                   is_complex,
    input  logic                                   first,
    input  logic                                   last,
    input  logic [cmm_pkg::LEVEL_WIDTH-1:0]        blank_level,
    output logic                                   d_valid,
    output logic [2*SAMPLE_WIDTH-1:0]              d_sum,
    output logic signed [SAMPLE_WIDTH-1:0]         d_re,
    output logic signed [SAMPLE_WIDTH-1:0]         d_im,
    output cmm_pkg::flags_t                        d_flags
);

    localparam int PW = 2 * SAMPLE_WIDTH;

    logic signed [SAMPLE_WIDTH-1:0] re_in;
    logic signed [SAMPLE_WIDTH-1:0] im_in;
    logic signed [32:0]             re_ext;
    logic signed [32:0]             im_ext;
    logic signed [32:0]             lvl_ext;
    cmm_pkg::flags_t                flags_in;

    // stage A: sample and blank flags
    logic                           a_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] a_re_reg;
    logic signed [SAMPLE_WIDTH-1:0] a_im_reg;
    cmm_pkg::flags_t                a_flags_reg;
    // stage B: magnitudes of the parts
    logic                           b_valid_reg;
    logic [SAMPLE_WIDTH-1:0]        b_ar_reg;
    logic [SAMPLE_WIDTH-1:0]        b_ai_reg;
    logic [SAMPLE_WIDTH-1:0]        b_ar_next;
    logic [SAMPLE_WIDTH-1:0]        b_ai_next;
    logic signed [SAMPLE_WIDTH-1:0] b_re_reg;
    logic signed [SAMPLE_WIDTH-1:0] b_im_reg;
    cmm_pkg::flags_t                b_flags_reg;
    // stage C: squares
    logic                           c_valid_reg;
    logic [PW-1:0]                  c_rr_reg;
    logic [PW-1:0]                  c_ii_reg;
    logic signed [SAMPLE_WIDTH-1:0] c_re_reg;
    logic signed [SAMPLE_WIDTH-1:0] c_im_reg;
    cmm_pkg::flags_t                c_flags_reg;
    // stage D: sum of squares
    logic                           d_valid_reg;
    logic [PW-1:0]                  d_sum_reg;
    logic signed [SAMPLE_WIDTH-1:0] d_re_reg;
    logic signed [SAMPLE_WIDTH-1:0] d_im_reg;
    cmm_pkg::flags_t                d_flags_reg;

    assign re_in   = real_part[SAMPLE_WIDTH-1:0];
    assign im_in   = imag_part[SAMPLE_WIDTH-1:0];
    assign re_ext  = 33'(re_in);
    assign im_ext  = 33'(im_in);
    assign lvl_ext = {2'b00, blank_level};

    always_comb
    begin
        flags_in.is_complex = is_complex;
        flags_in.first      = first;
        flags_in.last       = last;
        flags_in.re_blank   = (re_ext >= lvl_ext);
        flags_in.im_blank   = (im_ext >= lvl_ext);
    end

    // -x of the most negative value reads back correctly as unsigned
    assign b_ar_next = a_re_reg[SAMPLE_WIDTH-1] ? $unsigned(-a_re_reg) : $unsigned(a_re_reg);
    assign b_ai_next = a_im_reg[SAMPLE_WIDTH-1] ? $unsigned(-a_im_reg) : $unsigned(a_im_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_re_reg    <= re_in;
            a_im_reg    <= im_in;
            a_flags_reg <= flags_in;

            b_ar_reg    <= b_ar_next;
            b_ai_reg    <= b_ai_next;
            b_re_reg    <= a_re_reg;
            b_im_reg    <= a_im_reg;
            b_flags_reg <= a_flags_reg;

            c_rr_reg    <= PW'(b_ar_reg) * PW'(b_ar_reg);
            c_ii_reg    <= PW'(b_ai_reg) * PW'(b_ai_reg);
            c_re_reg    <= b_re_reg;
            c_im_reg    <= b_im_reg;
            c_flags_reg <= b_flags_reg;

            d_sum_reg   <= c_rr_reg + c_ii_reg;
            d_re_reg    <= c_re_reg;
            d_im_reg    <= c_im_reg;
            d_flags_reg <= c_flags_reg;
        end
    end

    assign d_valid = d_valid_reg;
    assign d_sum   = d_sum_reg;
    assign d_re    = d_re_reg;
    assign d_im    = d_im_reg;
    assign d_flags = d_flags_reg;

endmodule

// ===== design/cmm_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// cmm_sqrt_cell
// One digit of the integer square root; resolves one root bit per cell.
// ----------------------------------------------------------------------------
module cmm_sqrt_cell #(
    parameter int SAMPLE_WIDTH = cmm_pkg::SAMPLE_WIDTH_DEF,
    parameter int SIDE_WIDTH   = 2 * cmm_pkg::SAMPLE_WIDTH_DEF + cmm_pkg::FLAGS_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [2*SAMPLE_WIDTH-1:0] in_rad,
    input  logic [SAMPLE_WIDTH+1:0]   in_rem,
    input  logic [SAMPLE_WIDTH-1:0]   in_root,
    input  logic [SIDE_WIDTH-1:0]     in_side,
    output logic                      out_valid,
    output logic [2*SAMPLE_WIDTH-1:0] out_rad,
    output logic [SAMPLE_WIDTH+1:0]   out_rem,
    output logic [SAMPLE_WIDTH-1:0]   out_root,
    output logic [SIDE_WIDTH-1:0]     out_side
);

    localparam int PW = 2 * SAMPLE_WIDTH;
    localparam int RW = SAMPLE_WIDTH + 2;

    logic [RW-1:0]           rem_sh;
    logic [RW-1:0]           trial;
    logic                    take;
    logic [RW-1:0]           rem_next;
    logic [SAMPLE_WIDTH-1:0] root_next;
    logic [PW-1:0]           rad_next;

    logic                    valid_reg;
    logic [PW-1:0]           rad_reg;
    logic [RW-1:0]           rem_reg;
    logic [SAMPLE_WIDTH-1:0] root_reg;
    logic [SIDE_WIDTH-1:0]   side_reg;

    // remainder stays below 2^SAMPLE_WIDTH before the shift
    assign rem_sh    = {in_rem[SAMPLE_WIDTH-1:0], in_rad[PW-1 -: 2]};
    assign trial     = {in_root, 2'b01};
    assign take      = (rem_sh >= trial);
    assign rem_next  = take ? (rem_sh - trial) : rem_sh;
    assign root_next = {in_root[SAMPLE_WIDTH-2:0], take};
    assign rad_next  = {in_rad[PW-3:0], 2'b00};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

// ===== design/cmm_stats.sv =====
// ----------------------------------------------------------------------------
// cmm_stats
// Running extremes, blank counter and the result register.
// ----------------------------------------------------------------------------
`include "complex_min_max_tracker_defines.svh"

module cmm_stats #(
    parameter int SAMPLE_WIDTH = cmm_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = cmm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  logic                                   in_valid,
    input  logic [SAMPLE_WIDTH-1:0]                in_mag,
    input  logic signed [SAMPLE_WIDTH-1:0]         in_re,
    input  logic signed [SAMPLE_WIDTH-1:0]         in_im,
    input  cmm_pkg::flags_t                        in_flags,
    input  logic [cmm_pkg::LEVEL_WIDTH-1:0]        blank_level,
    output logic                                   out_valid,
    output logic signed [cmm_pkg::FIELD_WIDTH-1:0] real_min,
    output logic signed [cmm_pkg::FIELD_WIDTH-1:0] real_max,
    output logic signed [cmm_pkg::FIELD_WIDTH-1:0] imag_min,
    output logic signed [cmm_pkg::FIELD_WIDTH-1:0] imag_max,
    output logic [cmm_pkg::FIELD_WIDTH-1:0]        mag_min,
    output logic [cmm_pkg::FIELD_WIDTH-1:0]        mag_max,
    output logic [cmm_pkg::FIELD_WIDTH-1:0]        blank_count,
    output logic                                   complex_seen
);

    localparam int FW = cmm_pkg::FIELD_WIDTH;

    logic signed [FW-1:0]   lvl;
    logic signed [FW-1:0]   re32;
    logic signed [FW-1:0]   im32;
    logic [FW-1:0]          mag32;
    logic                   take_re;
    logic                   take_im;
    logic                   bump;

    logic signed [FW-1:0]   base_low_real;
    logic signed [FW-1:0]   base_high_real;
    logic signed [FW-1:0]   base_low_imag;
    logic signed [FW-1:0]   base_high_imag;
    logic [FW-1:0]          base_low_mag;
    logic [FW-1:0]          base_high_mag;
    logic [COUNT_WIDTH-1:0] base_cnt;
    logic                   base_seen;

    logic signed [FW-1:0]   low_real_reg,  low_real_next;
    logic signed [FW-1:0]   high_real_reg, high_real_next;
    logic signed [FW-1:0]   low_imag_reg,  low_imag_next;
    logic signed [FW-1:0]   high_imag_reg, high_imag_next;
    logic [FW-1:0]          low_mag_reg,   low_mag_next;
    logic [FW-1:0]          high_mag_reg,  high_mag_next;
    logic [COUNT_WIDTH-1:0] cnt_reg,       cnt_next;
    logic                   imag_seen_reg, imag_seen_next;
    logic [FW-1:0]          cnt_out;

    logic                   out_valid_reg;
    logic signed [FW-1:0]   real_min_reg;
    logic signed [FW-1:0]   real_max_reg;
    logic signed [FW-1:0]   imag_min_reg;
    logic signed [FW-1:0]   imag_max_reg;
    logic [FW-1:0]          mag_min_reg;
    logic [FW-1:0]          mag_max_reg;
    logic [FW-1:0]          blank_count_reg;
    logic                   complex_seen_reg;

    assign lvl   = {1'b0, blank_level};
    assign re32  = FW'(in_re);
    assign im32  = FW'(in_im);
    assign mag32 = FW'(in_mag);

    // a blanked real part drops the whole sample
    assign take_re = !in_flags.re_blank;
    assign take_im = take_re && in_flags.is_complex && !in_flags.im_blank;
    assign bump    = in_flags.re_blank || (in_flags.is_complex && in_flags.im_blank);

    always_comb
    begin
        // first restarts the statistics; real and imag extremes load from the current blank level
        base_low_real  = in_flags.first ? lvl          : low_real_reg;
        base_high_real = in_flags.first ? -lvl         : high_real_reg;
        base_low_imag  = in_flags.first ? lvl          : low_imag_reg;
        base_high_imag = in_flags.first ? -lvl         : high_imag_reg;
        base_low_mag   = in_flags.first ? '1           : low_mag_reg;
        base_high_mag  = in_flags.first ? '0           : high_mag_reg;
        base_cnt       = in_flags.first ? '0           : cnt_reg;
        base_seen      = in_flags.first ? 1'b0         : imag_seen_reg;

        low_real_next  = (take_re && re32 < base_low_real)   ? re32  : base_low_real;
        high_real_next = (take_re && re32 > base_high_real)  ? re32  : base_high_real;
        low_imag_next  = (take_im && im32 < base_low_imag)   ? im32  : base_low_imag;
        high_imag_next = (take_im && im32 > base_high_imag)  ? im32  : base_high_imag;
        low_mag_next   = (take_im && mag32 < base_low_mag)   ? mag32 : base_low_mag;
        high_mag_next  = (take_im && mag32 > base_high_mag)  ? mag32 : base_high_mag;
        cnt_next       = (bump && base_cnt != '1) ? (base_cnt + COUNT_WIDTH'(1)) : base_cnt;
        imag_seen_next = base_seen || take_im;
    end

    // result view of the counter clips at 32 bits
    generate
        if (COUNT_WIDTH > FW)
        begin : g_cnt_clip
            assign cnt_out = (|cnt_next[COUNT_WIDTH-1:FW]) ? '1 : cnt_next[FW-1:0];
        end
        else
        begin : g_cnt_ext
            assign cnt_out = FW'(cnt_next);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_real_reg  <= cmm_pkg::LOW_RESET;
            high_real_reg <= cmm_pkg::HIGH_RESET;
            low_imag_reg  <= cmm_pkg::LOW_RESET;
            high_imag_reg <= cmm_pkg::HIGH_RESET;
            low_mag_reg   <= '1;
            high_mag_reg  <= '0;
            cnt_reg       <= '0;
            imag_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (in_valid)
            begin
                low_real_reg  <= low_real_next;
                high_real_reg <= high_real_next;
                low_imag_reg  <= low_imag_next;
                high_imag_reg <= high_imag_next;
                low_mag_reg   <= low_mag_next;
                high_mag_reg  <= high_mag_next;
                cnt_reg       <= cnt_next;
                imag_seen_reg <= imag_seen_next;
            end
            out_valid_reg <= in_valid && in_flags.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid && in_flags.last)
        begin
            real_min_reg     <= low_real_next;
            real_max_reg     <= high_real_next;
            imag_min_reg     <= low_imag_next;
            imag_max_reg     <= high_imag_next;
            mag_min_reg      <= low_mag_next;
            mag_max_reg      <= high_mag_next;
            blank_count_reg  <= cnt_out;
            complex_seen_reg <= imag_seen_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign real_min     = real_min_reg;
    assign real_max     = real_max_reg;
    assign imag_min     = imag_min_reg;
    assign imag_max     = imag_max_reg;
    assign mag_min      = mag_min_reg;
    assign mag_max      = mag_max_reg;
    assign blank_count  = blank_count_reg;
    assign complex_seen = complex_seen_reg;

    `CMM_ASSERT_IMP(a_imag_order, clk, rst_n, imag_seen_reg, low_imag_reg <= high_imag_reg && low_mag_reg <= high_mag_reg)
    `CMM_ASSERT_IMP(a_mag_empty, clk, rst_n, out_valid_reg && !complex_seen_reg, mag_min_reg == '1 && mag_max_reg == '0)
    `CMM_ASSERT_NXT(a_cnt_mono, clk, rst_n, adv && in_valid && !in_flags.first, cnt_reg >= $past(cnt_reg))

endmodule

// ===== dv/complex_min_max_tracker_test.sv =====
// ----------------------------------------------------------------------------
// complex_min_max_tracker_test
// Self-checking bench for the running min/max tracker. A short table of
// directed samples and blank-level writes runs first. Random framed sample
// streams follow, one phase per blank level. A local model of the
// statistics predicts each emitted result (directed rows may carry a
// hand-written result instead), and the bench compares every field. The
// sender works in bursts and the receiver stalls in several patterns.
// ----------------------------------------------------------------------------
module complex_min_max_tracker_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS = 194;      // 8 random phases, ~1550 samples
    localparam int PIPE_DRAIN  = 48;       // drain wait longer than the whole pipe
    localparam int TIMEOUT_NS  = 6_000_000;

    // one input transaction
    typedef struct packed {
        logic signed [cmm_pkg::FIELD_WIDTH-1:0] real_part;
        logic signed [cmm_pkg::FIELD_WIDTH-1:0] imag_part;
        logic                                   is_complex;
        logic                                   first;
        logic                                   last;
    } sample_t;

    // one output transaction
    typedef struct packed {
        logic signed [cmm_pkg::FIELD_WIDTH-1:0] real_min;
        logic signed [cmm_pkg::FIELD_WIDTH-1:0] real_max;
        logic signed [cmm_pkg::FIELD_WIDTH-1:0] imag_min;
        logic signed [cmm_pkg::FIELD_WIDTH-1:0] imag_max;
        logic [cmm_pkg::FIELD_WIDTH-1:0]        mag_min;
        logic [cmm_pkg::FIELD_WIDTH-1:0]        mag_max;
        logic [cmm_pkg::FIELD_WIDTH-1:0]        blank_count;
        logic                                   complex_seen;
    } stats_t;

    typedef enum logic {ROW_SAMPLE, ROW_SET_LEVEL} row_kind_t;

    // directed step: a sample (with an optional hand-written result) or a
    // blank-level write carried in real_part
    typedef struct {
        row_kind_t kind;
        sample_t   smp;
        bit        typed;
        stats_t    stats;
    } step_row_t;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                                   clk = 1'b0;
    logic                                   rst_n;
    logic                                   psel;
    logic                                   penable;
    logic                                   pwrite;
    logic [cmm_pkg::ADDR_WIDTH-1:0]         paddr;
    logic [cmm_pkg::DATA_WIDTH-1:0]         pwdata;
    logic [cmm_pkg::DATA_WIDTH-1:0]         prdata;
    logic                                   pready;
    logic                                   in_valid;
    logic                                   in_stall;
    logic signed [cmm_pkg::FIELD_WIDTH-1:0] real_part;
    logic signed [cmm_pkg::FIELD_WIDTH-1:0] imag_part;
    logic                                   is_complex;
    logic                                   first;
    logic                                   last;
    logic                                   out_valid;
    logic                                   out_stall;
    logic signed [cmm_pkg::FIELD_WIDTH-1:0] real_min;
    logic signed [cmm_pkg::FIELD_WIDTH-1:0] real_max;
    logic signed [cmm_pkg::FIELD_WIDTH-1:0] imag_min;
    logic signed [cmm_pkg::FIELD_WIDTH-1:0] imag_max;
    logic [cmm_pkg::FIELD_WIDTH-1:0]        mag_min;
    logic [cmm_pkg::FIELD_WIDTH-1:0]        mag_max;
    logic [cmm_pkg::FIELD_WIDTH-1:0]        blank_count;
    logic                                   complex_seen;

    complex_min_max_tracker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .real_part    (real_part),
        .imag_part    (imag_part),
        .is_complex   (is_complex),
        .first        (first),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .real_min     (real_min),
        .real_max     (real_max),
        .imag_min     (imag_min),
        .imag_max     (imag_max),
        .mag_min      (mag_min),
        .mag_max      (mag_max),
        .blank_count  (blank_count),
        .complex_seen (complex_seen)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Statistics model: mirrors the tracker state, updated per accepted
    // transaction
    // ------------------------------------------------------------------
    logic [cmm_pkg::LEVEL_WIDTH-1:0]        level;
    logic signed [cmm_pkg::FIELD_WIDTH-1:0] lo_re, hi_re, lo_im, hi_im;
    logic [cmm_pkg::FIELD_WIDTH-1:0]        lo_mag, hi_mag;
    logic [cmm_pkg::FIELD_WIDTH-1:0]        blank_seen;
    logic                                   imag_taken;

    stats_t pending_stats[$];    // results owed by the DUT, oldest first
    int     mismatch_count = 0;
    int     burst_left     = 0;  // transactions left in the current sender burst
    stall_mode_t stall_mode = STALL_NONE;
    int     stall_left = 0;
    logic [2:0] stall_tick = '0;

    // floor(sqrt(n)), one result bit per step from the top
    function automatic logic [31:0] root_floor(input logic [63:0] n);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (32'd1 << b);
            if ({32'd0, t} * {32'd0, t} <= n)
                r = t;
        end
        return r;
    endfunction

    // empty statistics; real and imag extremes load from the current blank level
    function automatic void restart_stats();
        lo_re      = {1'b0, level};
        hi_re      = -$signed({1'b0, level});
        lo_im      = {1'b0, level};
        hi_im      = -$signed({1'b0, level});
        lo_mag     = '1;
        hi_mag     = '0;
        blank_seen = '0;
        imag_taken = 1'b0;
    endfunction

    function automatic void bump_blank();
        if (blank_seen != '1)
            blank_seen++;
    endfunction

    // returns 1 when the transaction emits a result
    function automatic bit track_sample(input sample_t s, output stats_t r);
        logic signed [cmm_pkg::FIELD_WIDTH-1:0] lvl;
        logic [63:0] ar;
        logic [63:0] ai;
        logic [31:0] mag;
        lvl = {1'b0, level};
        if (s.first)
            restart_stats();
        if (s.real_part >= lvl)
            bump_blank();                 // whole sample dropped
        else
        begin
            if (s.real_part > hi_re) hi_re = s.real_part;
            if (s.real_part < lo_re) lo_re = s.real_part;
            if (s.is_complex)
            begin
                if (s.imag_part >= lvl)
                    bump_blank();         // real update stands
                else
                begin
                    ar = 64'(s.real_part);
                    ai = 64'(s.imag_part);
                    if (s.real_part < 0) ar = -ar;
                    if (s.imag_part < 0) ai = -ai;
                    mag = root_floor(ar * ar + ai * ai);
                    if (mag > hi_mag) hi_mag = mag;
                    if (mag < lo_mag) lo_mag = mag;
                    if (s.imag_part > hi_im) hi_im = s.imag_part;
                    if (s.imag_part < lo_im) lo_im = s.imag_part;
                    imag_taken = 1'b1;
                end
            end
        end
        r = '{lo_re, hi_re, lo_im, hi_im, lo_mag, hi_mag, blank_seen, imag_taken};
        return s.last;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // one part value: small Q16.16, full range, near the blank level or its negative, or a corner value
    function automatic logic signed [31:0] pick_part(
        input logic [cmm_pkg::LEVEL_WIDTH-1:0] lv);
        logic signed [31:0] lvl;
        lvl = {1'b0, lv};
        case ($urandom_range(0, 11)) inside
            [0:3]: return 32'($urandom_range(0, 20'hF_FFFF)) - 32'h0008_0000;
            [4:6]: return $urandom;
            7:     return lvl;
            8:     return lvl - 1;
            9:     return -lvl;
            10:    return lvl - 1 - 32'($urandom_range(0, 255));
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function automatic step_row_t sample_row(input sample_t s);
        step_row_t r;
        r.kind  = ROW_SAMPLE;
        r.smp   = s;
        r.typed = 1'b0;
        r.stats = '0;
        return r;
    endfunction

    function automatic step_row_t typed_row(input sample_t s, input stats_t e);
        step_row_t r;
        r       = sample_row(s);
        r.typed = 1'b1;
        r.stats = e;
        return r;
    endfunction

    function automatic step_row_t level_row(input logic [cmm_pkg::LEVEL_WIDTH-1:0] v);
        step_row_t r;
        r      = sample_row('0);
        r.kind = ROW_SET_LEVEL;
        r.smp.real_part = {1'b0, v};
        return r;
    endfunction

    // hold the sender until every owed result is out, then let the pipe empty
    // (samples without last leave nothing to wait on)
    task automatic settle_pipe();
        in_valid = 1'b0;
        while (pending_stats.size() != 0)
            @(negedge clk);
        repeat (PIPE_DRAIN) @(negedge clk);
    endtask

    // one APB transfer: setup phase, then access phase until pready
    task automatic apb_access(input bit wr, input logic [cmm_pkg::DATA_WIDTH-1:0] wdata,
                              output logic [cmm_pkg::DATA_WIDTH-1:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = cmm_pkg::REG_BLANK_LEVEL;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // blank level write while idle, with readback
    task automatic write_level(input logic [cmm_pkg::LEVEL_WIDTH-1:0] v);
        logic [cmm_pkg::DATA_WIDTH-1:0] rd;
        settle_pipe();
        apb_access(1'b1, {1'b0, v}, rd);
        level = v;
        apb_access(1'b0, '0, rd);
        if (rd !== {1'b0, v})
        begin
            $error("blank_level: expected %h, actual %h", {1'b0, v}, rd);
            mismatch_count++;
        end
    endtask

    // drive one sample transaction; the model runs at the accepting edge
    task automatic send_sample(input sample_t s, input bit typed, input stats_t e);
        stats_t got;
        int     gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 19)) inside
                [0:9]:   gap = 0;
                [10:16]: gap = $urandom_range(1, 4);
                default: gap = $urandom_range(8, 30);
            endcase
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        {real_part, imag_part, is_complex, first, last} = s;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        if (track_sample(s, got))
            pending_stats.push_back(typed ? e : got);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern switches at random among none, light, heavy and periodic modes
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n !== 1'b1)
            out_stall = 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_left = $urandom_range(32, 300);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                STALL_NONE:  out_stall = 1'b0;
                STALL_LIGHT: out_stall = ($urandom_range(0, 2) == 0);
                STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
                default:     out_stall = (stall_tick >= 3'd5);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        stats_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_stats.size() == 0)
            begin
                $error("result transaction with no expectation waiting");
                mismatch_count++;
            end
            else
            begin
                want = pending_stats.pop_front();
                check_field("real_min", want.real_min, real_min);
                check_field("real_max", want.real_max, real_max);
                check_field("imag_min", want.imag_min, imag_min);
                check_field("imag_max", want.imag_max, imag_max);
                check_field("mag_min", want.mag_min, mag_min);
                check_field("mag_max", want.mag_max, mag_max);
                check_field("blank_count", want.blank_count, blank_count);
                check_field("complex_seen", {31'd0, want.complex_seen},
                            {31'd0, complex_seen});
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        step_row_t                       directed[$];
        logic [cmm_pkg::LEVEL_WIDTH-1:0] phase_levels[8];
        sample_t                         s;
        int                              sent;
        int                              n;
        int                              frame_kind;

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        real_part  = '0;
        imag_part  = '0;
        is_complex = 1'b0;
        first      = 1'b0;
        last       = 1'b0;
        out_stall  = 1'b0;
        level      = cmm_pkg::LEVEL_RESET;
        restart_stats();

        // --- directed table (level at reset value unless a row changes it) ---
        // real part at the blank level: nothing accepted, one blank
        directed.push_back(typed_row('{32'h7FFF_FFFF, 32'h0, 1'b0, 1'b1, 1'b1},
            '{32'h7FFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0001,
              32'hFFFF_FFFF, 32'h0, 32'd1, 1'b0}));
        // most negative both parts: below minus level, maxima stay put
        directed.push_back(typed_row('{32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 1'b1},
            '{32'h8000_0000, 32'h8000_0001, 32'h8000_0000, 32'h8000_0001,
              32'hB504_F333, 32'hB504_F333, 32'd0, 1'b1}));
        // imag blanked, real kept
        directed.push_back(typed_row('{32'h0, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1},
            '{32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0001,
              32'hFFFF_FFFF, 32'h0, 32'd1, 1'b0}));
        // real-only sample: imag part ignored even at the level
        directed.push_back(typed_row('{32'hFFFF_FFFB, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1},
            '{32'hFFFF_FFFB, 32'hFFFF_FFFB, 32'h7FFF_FFFF, 32'h8000_0001,
              32'hFFFF_FFFF, 32'h0, 32'd0, 1'b0}));
        // zero sample, zero magnitude
        directed.push_back(typed_row('{32'h0, 32'h0, 1'b1, 1'b1, 1'b1},
            '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 1'b1}));
        // largest accepted values, largest magnitude from positive parts
        directed.push_back(sample_row('{32'h7FFF_FFFE, 32'h7FFF_FFFE, 1'b1, 1'b1, 1'b1}));
        // multi-sample frame
        directed.push_back(sample_row('{32'h0001_8000, 32'hFFFD_C000, 1'b1, 1'b1, 1'b0}));
        directed.push_back(sample_row('{32'hFFFD_0000, 32'h0004_0000, 1'b1, 1'b0, 1'b0}));
        directed.push_back(sample_row('{32'h0064_0000, 32'h1234_5678, 1'b0, 1'b0, 1'b0}));
        directed.push_back(sample_row('{32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0, 1'b1}));
        // emit again without a restart: statistics accumulate
        directed.push_back(sample_row('{32'h8000_0000, 32'h7FFF_FFFE, 1'b1, 1'b0, 1'b1}));
        // level zero: every non-negative part is blanked
        directed.push_back(level_row(31'd0));
        directed.push_back(sample_row('{32'h0, 32'h5, 1'b1, 1'b1, 1'b1}));
        directed.push_back(sample_row('{32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, 1'b1}));
        directed.push_back(sample_row('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1}));
        // level change alone: blanking moves, stored extremes do not
        directed.push_back(level_row(31'h0000_0100));
        directed.push_back(sample_row('{32'h0000_0080, 32'h0000_0200, 1'b1, 1'b0, 1'b1}));
        directed.push_back(sample_row('{32'h0000_0100, 32'h0, 1'b0, 1'b1, 1'b1}));
        directed.push_back(level_row(31'h7FFF_FFFF));
        // a restart discards a frame that never emitted
        directed.push_back(sample_row('{32'h0003_0000, 32'h0004_0000, 1'b1, 1'b1, 1'b0}));
        directed.push_back(sample_row('{32'hFFF9_0000, 32'h0, 1'b0, 1'b1, 1'b1}));

        phase_levels = '{31'h7FFF_FFFF, 31'd0, 31'd1, 31'($urandom),
                         31'h0001_0000, 31'($urandom_range(0, 16'hFFFF)),
                         31'h7FFF_FFFE, 31'h4000_0000};

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_SET_LEVEL)
                write_level(directed[i].smp.real_part[cmm_pkg::LEVEL_WIDTH-1:0]);
            else
                send_sample(directed[i].smp, directed[i].typed, directed[i].stats);
        end

        // --- random phases, one blank level each; the write drains first ---
        foreach (phase_levels[p])
        begin
            write_level(phase_levels[p]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // noise: flags at random, frames broken anywhere
                    n = $urandom_range(1, 6);
                    repeat (n)
                    begin
                        s.real_part  = pick_part(level);
                        s.imag_part  = ($urandom_range(0, 1) == 0) ? pick_part(level)
                                                                   : 32'($urandom);
                        s.is_complex = 1'($urandom_range(0, 1));
                        s.first      = ($urandom_range(0, 3) == 0);
                        s.last       = ($urandom_range(0, 3) == 0);
                        send_sample(s, 1'b0, '0);
                    end
                end
                else
                begin
                    // well-formed frame: first on the head, last on the tail
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
                    frame_kind = $urandom_range(0, 2);
                    for (int k = 0; k < n; k++)
                    begin
                        s.real_part = pick_part(level);
                        s.imag_part = pick_part(level);
                        case (frame_kind)
                            0:       s.is_complex = 1'b0;
                            1:       s.is_complex = 1'b1;
                            default: s.is_complex = 1'($urandom_range(0, 1));
                        endcase
                        s.first = (k == 0);
                        s.last  = (k == n - 1);
                        send_sample(s, 1'b0, '0);
                    end
                end
                sent += n;
            end
        end

        settle_pipe();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hang guard
    initial
    begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/cmm_pkg.sv
design/cmm_front.sv
design/cmm_sqrt_cell.sv
design/cmm_stats.sv
design/complex_min_max_tracker.sv
dv/complex_min_max_tracker_test.sv
